### rtl/core/fq_pkg.sv
// Shared types and constants for the bounded FIFO queue.
// Depends on nothing; imported by every module of the block.
package fq_pkg;

    // Widths fixed by the item format, and the reset capacity
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned ADDR_MAX_W = 12;
    localparam int unsigned CAP_RESET  = 16;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Where the front value of a result comes from
    typedef enum logic [1:0] {
        FS_KEEP = 2'd0,
        FS_MEM  = 2'd1,
        FS_PUSH = 2'd2
    } front_src_t;

    // Access request from the controller to the entry store
    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        data_t                 wr_data;
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

### rtl/core/fq_store.sv
// Entry store of the queue: one write port and one registered read port.
// Depends on fq_pkg for the request struct and data type.
module fq_store #(
    parameter int unsigned DEPTH = 16
) (
    input  logic             aclk,
    input  fq_pkg::mem_req_t req,
    output fq_pkg::data_t    rd_data
);
    import fq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    data_t mem [DEPTH];
    data_t rd_data_reg;

    // Write the pushed beat at the rear slot
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
    end

    // Read the new front slot; hold the data until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/fq_ctrl.sv
// Queue controller: pointers, entry count, capacity register, result stage
// and output register. Depends on fq_pkg; drives the fq_store request.
module fq_ctrl #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  fq_pkg::cnt_t             cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  fq_pkg::data_t            s_push_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output fq_pkg::cnt_t             m_count,
    output logic                     m_is_empty,
    output logic                     m_is_full,
    output fq_pkg::data_t            m_front_value,
    output fq_pkg::data_t            m_rear_value,
    output fq_pkg::mem_req_t         mem_req,
    input  fq_pkg::data_t            mem_rd_data
);
    import fq_pkg::*;

    localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CAP_LIMIT = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == PTR_LAST) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    cnt_t          cap_reg;
    cnt_t          count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    data_t         rear_reg, rear_next;
    data_t         front_reg;

    logic          p1_valid_reg;
    status_t       p1_status_reg, p1_status_next;
    front_src_t    p1_fsrc_reg, p1_fsrc_next;
    data_t         p1_value_reg;

    logic          m_valid_reg;
    status_t       m_status_reg;
    cnt_t          m_count_reg;
    logic          m_is_empty_reg;
    logic          m_is_full_reg;
    data_t         m_front_reg;
    data_t         m_rear_reg;

    cnt_t          eff_cap;
    logic          out_free;
    logic          p1_adv;
    logic          accept;
    data_t         front_now;
    logic          res_empty;

    // Clamp capacity to one entry at least and to the store depth at most
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(cap_reg) > CAP_LIMIT) begin
            eff_cap = CNT_W'(CAP_LIMIT);
        end else begin
            eff_cap = cap_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // Decode the beat: new pointers, count, rear and store access
    always_comb begin
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rear_next      = rear_reg;
        p1_status_next = ST_DONE;
        p1_fsrc_next   = FS_KEEP;
        mem_req        = '0;
        mem_req.wr_addr = ADDR_MAX_W'(tail_reg);
        mem_req.wr_data = s_push_value;
        mem_req.rd_addr = ADDR_MAX_W'(ptr_inc(head_reg));
        unique case (s_opcode)
            OP_PUSH: begin
                if (count_reg >= eff_cap) begin
                    p1_status_next = ST_FULL;
                end else begin
                    count_next    = count_reg + 1'b1;
                    tail_next     = ptr_inc(tail_reg);
                    rear_next     = s_push_value;
                    mem_req.wr_en = accept;
                    if (count_reg == '0) begin
                        p1_fsrc_next = FS_PUSH;
                    end
                end
            end
            OP_POP: begin
                if (count_reg == '0) begin
                    p1_status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                    head_next  = ptr_inc(head_reg);
                    if (count_reg > CNT_W'(1)) begin
                        p1_fsrc_next  = FS_MEM;
                        mem_req.rd_en = accept;
                    end
                end
            end
            default: begin
                // query: state unchanged
            end
        endcase
    end

    // Select the front value of the item in the result stage
    always_comb begin
        unique case (p1_fsrc_reg)
            FS_MEM:  front_now = mem_rd_data;
            FS_PUSH: front_now = p1_value_reg;
            default: front_now = front_reg;
        endcase
    end

    assign res_empty = (count_reg == '0);

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(CAP_RESET);
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    // Advance queue state on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else if (accept) begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rear_reg      <= rear_next;
            p1_status_reg <= p1_status_next;
            p1_fsrc_reg   <= p1_fsrc_next;
            p1_value_reg  <= s_push_value;
        end
        if (p1_adv) begin
            front_reg <= front_now;
        end
    end

    // Result stage occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    // Output register: load from the result stage, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_status_reg   <= p1_status_reg;
            m_count_reg    <= count_reg;
            m_is_empty_reg <= res_empty;
            m_is_full_reg  <= (count_reg >= eff_cap);
            m_front_reg    <= res_empty ? data_t'(0) : front_now;
            m_rear_reg     <= res_empty ? data_t'(0) : rear_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_count       = m_count_reg;
    assign m_is_empty    = m_is_empty_reg;
    assign m_is_full     = m_is_full_reg;
    assign m_front_value = m_front_reg;
    assign m_rear_value  = m_rear_reg;

endmodule

### rtl/core/bounded_fifo_queue.sv
// Bounded FIFO queue of signed 32-bit values: top level.
// Depends on fq_pkg, fq_ctrl and fq_store.
//
// Usage:
//   Input channel s_*: one beat is a push (opcode 0), pop (1) or query (2);
//   opcode 3 acts as a query. s_push_value is used on a push only.
//   Output channel m_*: exactly one beat per input beat, in order, with the
//   status, count, empty/full flags and front/rear values after the operation.
//   Front and rear read 0 while the queue is empty.
//   cfg_we/cfg_wdata write the capacity (0 acts as 1, above DEPTH acts as
//   DEPTH); write it only while no beat is in flight.
// Path: accepted beat -> result stage -> output register. Throughput: one
//   beat per clock unless stalled; a pop reads the new front from the single
//   read port of the entry store, and its data lands in the result stage.
// Reset: queue empty, capacity 16, both channels idle; the store is not
//   cleared, as no entry is read before it is written.
// Stall: a result held by a low m_ready blocks the result stage, and s_ready
//   falls once both the result stage and the output register are full.
module bounded_fifo_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  fq_pkg::cnt_t  cfg_wdata,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_opcode,
    input  fq_pkg::data_t s_push_value,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output fq_pkg::cnt_t  m_count,
    output logic          m_is_empty,
    output logic          m_is_full,
    output fq_pkg::data_t m_front_value,
    output fq_pkg::data_t m_rear_value
);
    import fq_pkg::*;

    mem_req_t mem_req;
    data_t    mem_rd_data;

    fq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full),
        .m_front_value(m_front_value),
        .m_rear_value (m_rear_value),
        .mem_req      (mem_req),
        .mem_rd_data  (mem_rd_data)
    );

    fq_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk   (aclk),
        .req    (mem_req),
        .rd_data(mem_rd_data)
    );

endmodule

### rtl/core/fq_checker.sv
// Port-level checks on the bounded FIFO queue, bound to the top level.
// Depends on fq_pkg for the status codes.
module fq_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input logic [1:0]    m_status,
    input fq_pkg::cnt_t  m_count,
    input logic          m_is_empty,
    input logic          m_is_full,
    input fq_pkg::data_t m_front_value,
    input fq_pkg::data_t m_rear_value
);
    import fq_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count)
            && $stable(m_front_value) && $stable(m_status))
        else $error("result beat changed while stalled");

    // Empty flag agrees with the count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_is_empty == (m_count == '0))
        else $error("empty flag disagrees with count");

    // Empty queue shows zero values
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_front_value == '0 && m_rear_value == '0)
        else $error("values not zero on empty queue");

    // A rejected push means the queue is full
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_is_full && !m_is_empty)
        else $error("push rejected while not full");

    // A single entry is both front and rear
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count == CNT_W'(1) |-> m_front_value == m_rear_value)
        else $error("front and rear differ with one entry");

endmodule

bind bounded_fifo_queue fq_checker u_fq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_count      (m_count),
    .m_is_empty   (m_is_empty),
    .m_is_full    (m_is_full),
    .m_front_value(m_front_value),
    .m_rear_value (m_rear_value)
);

### dv/testbench.sv
// Self-checking testbench for bounded_fifo_queue: directed and random traffic.
// Depends on fq_pkg and the RTL under rtl/core; keeps its own queue predictor.
module testbench;

    import fq_pkg::*;

    localparam int unsigned QDEPTH       = 16;
    localparam logic [1:0]  OPC_RESERVED = 2'd3;

    // One expected result beat
    typedef struct packed {
        status_t status;
        cnt_t    count;
        logic    is_empty;
        logic    is_full;
        data_t   front;
        data_t   rear;
    } queue_result_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    cnt_t          cfg_wdata;
    logic          s_valid;
    logic          s_ready;
    logic [1:0]    s_opcode;
    data_t         s_push_value;
    logic          m_valid;
    logic          m_ready;
    logic [1:0]    m_status;
    cnt_t          m_count;
    logic          m_is_empty;
    logic          m_is_full;
    data_t         m_front_value;
    data_t         m_rear_value;

    // Predictor state: held values, oldest first, and the capacity register
    data_t         model_entries[$];
    cnt_t          model_cap;
    queue_result_t pending_results[$];

    // Idling controls shared by the stimulus and the receiver
    bit            send_gaps;
    bit            recv_stalls;
    int unsigned   hold_len;

    int unsigned   errors;
    int unsigned   n_beats;
    int unsigned   n_pushes_ok;
    int unsigned   n_push_rejects;
    int unsigned   n_pop_rejects;
    int unsigned   n_full_seen;
    int unsigned   n_input_stalls;

    bounded_fifo_queue #(
        .DEPTH(QDEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full),
        .m_front_value(m_front_value),
        .m_rear_value (m_rear_value)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Apply one operation to the predictor and return the result it gives
    function automatic queue_result_t apply_queue_op(logic [1:0] opc, data_t val);
        queue_result_t res;
        int unsigned   eff_cap;
        eff_cap = (model_cap == 0) ? 1 : ((model_cap > QDEPTH) ? QDEPTH : model_cap);
        res.status = ST_DONE;
        case (opc)
            OP_PUSH: begin
                if (model_entries.size() >= eff_cap) begin
                    res.status = ST_FULL;
                    n_push_rejects++;
                end else begin
                    model_entries.push_back(val);
                    n_pushes_ok++;
                end
            end
            OP_POP: begin
                if (model_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                    n_pop_rejects++;
                end else begin
                    void'(model_entries.pop_front());
                end
            end
            default: ;
        endcase
        res.count    = cnt_t'(model_entries.size());
        res.is_empty = (model_entries.size() == 0);
        res.is_full  = (model_entries.size() >= eff_cap);
        res.front    = res.is_empty ? '0 : model_entries[0];
        res.rear     = res.is_empty ? '0 : model_entries[model_entries.size() - 1];
        if (res.is_full)
            n_full_seen++;
        return res;
    endfunction

    // Offer one beat, hold it until accepted, then record its expected result
    task automatic offer_op(input logic [1:0] opc, input data_t val);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= opc;
        s_push_value <= val;
        do begin
            @(posedge aclk);
            if (!s_ready)
                n_input_stalls++;
        end while (!s_ready);
        pending_results.push_back(apply_queue_op(opc, val));
        n_beats++;
    endtask

    // Drain everything in flight, then write the capacity register
    task automatic set_capacity(input cnt_t cap);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        model_cap = cap;
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(11))
            0:       return data_t'(32'h8000_0000);
            1:       return data_t'(32'h7fff_ffff);
            2:       return data_t'(32'hffff_ffff);
            3:       return data_t'(32'h0000_0000);
            4:       return data_t'(32'haaaa_aaaa);
            5:       return data_t'(32'h5555_5555);
            default: return data_t'($urandom);
        endcase
    endfunction

    // Pick an opcode, leaning towards pushes or pops by push_pct
    function automatic logic [1:0] pick_opcode(int unsigned push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return OP_QUERY;
        if (r < 8)
            return OPC_RESERVED;
        return ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: stall at random, hold off on request, check each result beat
    initial begin
        int unsigned   stall;
        int unsigned   span;
        queue_result_t want;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_len > 0) begin
                span     = hold_len;
                hold_len = 0;
                m_ready <= 1'b0;
                repeat (span) @(posedge aclk);
            end
            stall = recv_stalls ? $urandom_range(18) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && hold_len == 0);
            if (m_valid) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, expected none actual %0d",
                             $time, m_count);
                end else begin
                    want = pending_results.pop_front();
                    report_field("status", 32'(want.status), 32'(m_status));
                    report_field("count", 32'(want.count), 32'(m_count));
                    report_field("is_empty", 32'(want.is_empty), 32'(m_is_empty));
                    report_field("is_full", 32'(want.is_full), 32'(m_is_full));
                    report_field("front_value", want.front, m_front_value);
                    report_field("rear_value", want.rear, m_rear_value);
                end
            end
        end
    end

    // Empty-queue queries, the reserved opcode, extreme values and underflow
    task automatic test_directed_edges();
        offer_op(OP_QUERY, data_t'(32'h1234_5678));
        offer_op(OPC_RESERVED, data_t'(32'hffff_ffff));
        offer_op(OP_POP, data_t'(32'h7fff_ffff));
        offer_op(OP_PUSH, data_t'(32'h8000_0000));
        offer_op(OP_PUSH, data_t'(32'h7fff_ffff));
        offer_op(OP_PUSH, data_t'(32'h0000_0000));
        offer_op(OP_PUSH, data_t'(32'hffff_ffff));
        offer_op(OP_POP, '0);
        offer_op(OP_POP, '0);
        offer_op(OP_POP, '0);
        offer_op(OP_POP, '0);
        offer_op(OP_POP, '0);
    endtask

    // Capacity zero behaves as one
    task automatic test_capacity_zero();
        set_capacity(cnt_t'(0));
        offer_op(OP_PUSH, data_t'(32'haaaa_aaaa));
        offer_op(OP_PUSH, data_t'(32'h5555_5555));
        offer_op(OP_POP, '0);
    endtask

    // Lower the capacity below the count: nothing is lost, pushes refused until it drains
    task automatic test_capacity_shrink();
        set_capacity(cnt_t'(16));
        repeat (4) offer_op(OP_PUSH, pick_value());
        set_capacity(cnt_t'(2));
        offer_op(OP_PUSH, pick_value());
        offer_op(OP_QUERY, '0);
        repeat (3) offer_op(OP_POP, '0);
        offer_op(OP_PUSH, pick_value());
    endtask

    // Random traffic in bursts that sweep between full and empty
    task automatic test_random_traffic(input cnt_t cap, input int unsigned n_items,
                                       input bit gaps, input bit stalls);
        int unsigned push_pct;
        set_capacity(cap);
        send_gaps   = gaps;
        recv_stalls = stalls;
        push_pct    = 50;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 16 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            offer_op(pick_opcode(push_pct), pick_value());
        end
    endtask

    // Hold the receiver off while the sender keeps offering beats back to back
    task automatic test_backpressure();
        set_capacity(cnt_t'(16));
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        hold_len    = 150;
        for (int unsigned i = 0; i < 40; i++)
            offer_op(pick_opcode(70), pick_value());
    endtask

    initial begin
        int unsigned waited;
        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_opcode     <= OP_QUERY;
        s_push_value <= '0;
        model_cap    = cnt_t'(CAP_RESET);
        send_gaps    = 1'b1;
        recv_stalls  = 1'b1;
        hold_len     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_capacity_zero();
        test_capacity_shrink();
        test_random_traffic(cnt_t'(16), 200, 1'b1, 1'b1);
        test_random_traffic(cnt_t'(1), 80, 1'b1, 1'b0);
        test_random_traffic(cnt_t'(0), 60, 1'b0, 1'b1);
        test_random_traffic(cnt_t'(31), 160, 1'b0, 1'b0);
        test_random_traffic(cnt_t'(17), 80, 1'b1, 1'b1);
        test_random_traffic(cnt_t'($urandom_range(15, 2)), 120, 1'b1, 1'b1);
        test_backpressure();
        test_random_traffic(cnt_t'(16), 60, 1'b0, 1'b1);

        // Drain the tail and let the pipeline settle
        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: results never arrived, expected 0 outstanding actual %0d",
                     $time, pending_results.size());
        end

        $display("Ran %0d beats over capacities 0, 1, 2..15, 16, 17 and 31, with a long stall",
                 n_beats);
        $display("Stored %0d pushes, refused %0d full pushes and %0d empty pops, %0d input stalls",
                 n_pushes_ok, n_push_rejects, n_pop_rejects, n_input_stalls);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(8 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
